FILE: design/sfa_pkg.sv
// Shared types and fixed widths for the spectrum frame averager.
// No dependencies; every other design file uses this package.
package sfa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 5;

    typedef struct packed {
        logic valid;
        logic drop;
        logic use_mem;
        logic frame_end;
    } sfa_ctrl_t;

    typedef struct packed {
        logic valid;
        logic frame_end;
    } sfa_tag_t;

endpackage

FILE: design/sfa_if.sv
// Handshake channels of the spectrum frame averager: pixel input and average output.
// Depends on sfa_pkg for the sample width.
interface sfa_in_if;
    logic                          valid;
    logic                          ready;
    logic [sfa_pkg::SAMPLE_W-1:0]  sample;
    logic                          last_in_frame;
    logic                          restart;

    modport source (output valid, output sample, output last_in_frame, output restart,
                    input ready);
    modport sink   (input valid, input sample, input last_in_frame, input restart,
                    output ready);
endinterface

interface sfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfa_pkg::SAMPLE_W-1:0]  avg_sample;
    logic                          frame_end;

    modport source (output valid, output avg_sample, output frame_end, input ready);
    modport sink   (input valid, input avg_sample, input frame_end, output ready);
endinterface

FILE: design/sfa_front.sv
// Frame sequencer: frame limit register, history ring pointers, pixel counter and stage 1.
// Depends on sfa_pkg and sfa_in_if.
module sfa_front #(
    parameter int MAX_FRAMES = 16,
    parameter int PIXELS     = 2048,
    parameter int HELD_W     = 5,
    parameter int SLOT_W     = 4,
    parameter int PIX_W      = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          cfg_we,
    input  logic [sfa_pkg::LIMIT_W-1:0]   cfg_wdata,
    sfa_in_if.sink                        pixels,
    output logic [PIX_W-1:0]              rd_pix,
    output logic [SLOT_W-1:0]             rd_slot,
    output sfa_pkg::sfa_ctrl_t            s1_ctrl,
    output logic [sfa_pkg::SAMPLE_W-1:0]  s1_sample,
    output logic [PIX_W-1:0]              s1_pix,
    output logic [SLOT_W-1:0]             s1_old,
    output logic [SLOT_W-1:0]             s1_new,
    output logic [HELD_W-1:0]             s1_held
);
    import sfa_pkg::*;

    localparam int LW = (HELD_W > LIMIT_W) ? HELD_W : LIMIT_W;

    logic [LIMIT_W-1:0] limit_reg;
    logic [HELD_W-1:0]  held_reg;
    logic [SLOT_W-1:0]  old_reg;
    logic [SLOT_W-1:0]  new_reg;
    logic [PIX_W-1:0]   pos_reg;
    logic               drop_reg;

    logic [LW-1:0]      lim_wide;
    logic [HELD_W-1:0]  lim_eff;
    logic [HELD_W-1:0]  held_pre;
    logic [HELD_W-1:0]  held_next;
    logic [SLOT_W-1:0]  old_next;
    logic [SLOT_W-1:0]  new_next;
    logic               drop_next;
    logic               use_mem;
    logic               ending;
    logic               accept;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] v);
        logic [SLOT_W-1:0] r;
        if (v == SLOT_W'(MAX_FRAMES - 1))
        begin
            r = '0;
        end
        else
        begin
            r = v + SLOT_W'(1);
        end
        return r;
    endfunction

    assign pixels.ready = adv;
    assign accept       = pixels.valid && adv;

    always_comb
    begin
        lim_wide = LW'(limit_reg);
        if (limit_reg == '0)
        begin
            lim_eff = HELD_W'(1);
        end
        else if (lim_wide > LW'(MAX_FRAMES))
        begin
            lim_eff = HELD_W'(MAX_FRAMES);
        end
        else
        begin
            lim_eff = HELD_W'(lim_wide);
        end
    end

    // open a frame: empty on restart, advance the newest slot, retire the oldest when full
    always_comb
    begin
        held_pre  = pixels.restart ? '0 : held_reg;
        held_next = held_reg;
        old_next  = old_reg;
        new_next  = new_reg;
        drop_next = drop_reg;
        if (pos_reg == '0)
        begin
            if (held_pre == '0)
            begin
                held_next = HELD_W'(1);
                old_next  = '0;
                new_next  = '0;
                drop_next = 1'b0;
            end
            else
            begin
                new_next = slot_inc(new_reg);
                if (held_pre >= lim_eff)
                begin
                    drop_next = 1'b1;
                    held_next = held_pre;
                end
                else
                begin
                    drop_next = 1'b0;
                    held_next = held_pre + HELD_W'(1);
                end
            end
        end
        use_mem = !(held_next <= HELD_W'(1) && !drop_next);
        ending  = pixels.last_in_frame || (pos_reg == PIX_W'(PIXELS - 1));
    end

    assign rd_pix  = pos_reg;
    assign rd_slot = old_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(1);
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            old_reg  <= '0;
            new_reg  <= '0;
            pos_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            new_reg  <= new_next;
            old_reg  <= (ending && drop_next) ? slot_inc(old_next) : old_next;
            pos_reg  <= ending ? '0 : pos_reg + PIX_W'(1);
            drop_reg <= ending ? 1'b0 : drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl <= '0;
        end
        else if (adv)
        begin
            s1_ctrl.valid     <= accept;
            s1_ctrl.drop      <= drop_next;
            s1_ctrl.use_mem   <= use_mem;
            s1_ctrl.frame_end <= ending;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sample <= pixels.sample;
            s1_pix    <= pos_reg;
            s1_old    <= old_next;
            s1_new    <= new_next;
            s1_held   <= held_next;
        end
    end

endmodule

FILE: design/sfa_accum.sv
// Frame history and running pixel sums: two memories, read forwarding and stage 2.
// Depends on sfa_pkg; fed by sfa_front.
module sfa_accum #(
    parameter int PIXELS = 2048,
    parameter int HELD_W = 5,
    parameter int SLOT_W = 4,
    parameter int PIX_W  = 11,
    parameter int SUM_W  = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [PIX_W-1:0]              rd_pix,
    input  logic [SLOT_W-1:0]             rd_slot,
    input  sfa_pkg::sfa_ctrl_t            s1_ctrl,
    input  logic [sfa_pkg::SAMPLE_W-1:0]  s1_sample,
    input  logic [PIX_W-1:0]              s1_pix,
    input  logic [SLOT_W-1:0]             s1_old,
    input  logic [SLOT_W-1:0]             s1_new,
    input  logic [HELD_W-1:0]             s1_held,
    output sfa_pkg::sfa_tag_t             s2_tag,
    output logic [SUM_W-1:0]              s2_sum,
    output logic [HELD_W-1:0]             s2_held
);
    import sfa_pkg::*;

    localparam int STORE_DEPTH = 2 ** (SLOT_W + PIX_W);

    logic [SUM_W-1:0]    sums_mem  [PIXELS];
    logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];

    logic [SUM_W-1:0]    sums_rd_reg;
    logic [SAMPLE_W-1:0] store_rd_reg;

    logic [PIX_W-1:0]    s2_pix;
    logic [SLOT_W-1:0]   s2_slot;
    logic [SAMPLE_W-1:0] s2_sample;

    logic [SUM_W-1:0]    sums_fwd;
    logic [SAMPLE_W-1:0] store_fwd;
    logic [SUM_W-1:0]    sum_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sums_rd_reg  <= sums_mem[rd_pix];
            store_rd_reg <= store_mem[{rd_slot, rd_pix}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_ctrl.valid)
        begin
            sums_mem[s1_pix]           <= sum_next;
            store_mem[{s1_new, s1_pix}] <= s1_sample;
        end
    end

    // take the item one ahead when it wrote the same entry in the cycle this one was read
    always_comb
    begin
        sums_fwd  = sums_rd_reg;
        store_fwd = store_rd_reg;
        if (s2_tag.valid && s2_pix == s1_pix)
        begin
            sums_fwd = s2_sum;
            if (s2_slot == s1_old)
            begin
                store_fwd = s2_sample;
            end
        end
        if (s1_ctrl.use_mem)
        begin
            sum_next = sums_fwd - (s1_ctrl.drop ? SUM_W'(store_fwd) : '0)
                       + SUM_W'(s1_sample);
        end
        else
        begin
            sum_next = SUM_W'(s1_sample);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag <= '0;
        end
        else if (adv)
        begin
            s2_tag.valid     <= s1_ctrl.valid;
            s2_tag.frame_end <= s1_ctrl.frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sum    <= sum_next;
            s2_held   <= s1_held;
            s2_pix    <= s1_pix;
            s2_slot   <= s1_new;
            s2_sample <= s1_sample;
        end
    end

endmodule

FILE: design/sfa_divide.sv
// Pipelined floor division of a pixel sum by the frame count via a reciprocal table.
// Depends on sfa_pkg; stages 3 and 4 plus the final correction.
module sfa_divide #(
    parameter int MAX_FRAMES = 16,
    parameter int HELD_W     = 5,
    parameter int SUM_W      = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  sfa_pkg::sfa_tag_t             in_tag,
    input  logic [SUM_W-1:0]              in_sum,
    input  logic [HELD_W-1:0]             in_held,
    output sfa_pkg::sfa_tag_t             out_tag,
    output logic [sfa_pkg::SAMPLE_W-1:0]  out_avg
);
    import sfa_pkg::*;

    localparam int              RECIP_W = SUM_W + 1;
    localparam int              PROD_W  = SUM_W + RECIP_W;
    localparam int              BACK_W  = SUM_W + HELD_W;
    localparam longint unsigned ONE_K   = 64'd1 << SUM_W;

    logic [RECIP_W-1:0] recip_tab [2 ** HELD_W];

    for (genvar Dv = 0; Dv < 2 ** HELD_W; Dv++)
    begin : g_recip
        if (Dv == 0 || Dv > MAX_FRAMES)
        begin : g_unused
            assign recip_tab[Dv] = '0;
        end
        else
        begin : g_used
            localparam longint unsigned RV = ONE_K / Dv;
            assign recip_tab[Dv] = RECIP_W'(RV);
        end
    end

    logic [PROD_W-1:0] prod;
    logic [BACK_W-1:0] back;
    logic [SUM_W-1:0]  rem;
    logic [SUM_W-1:0]  quot;

    sfa_tag_t          s3_tag;
    logic [SUM_W-1:0]  s3_q;
    logic [SUM_W-1:0]  s3_sum;
    logic [HELD_W-1:0] s3_held;

    sfa_tag_t          s4_tag;
    logic [SUM_W-1:0]  s4_q;
    logic [SUM_W-1:0]  s4_back;
    logic [SUM_W-1:0]  s4_sum;
    logic [HELD_W-1:0] s4_held;

    // estimate is the true quotient or one below it
    assign prod = PROD_W'(in_sum) * PROD_W'(recip_tab[in_held]);
    assign back = BACK_W'(s3_q) * BACK_W'(s3_held);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_tag <= '0;
            s4_tag <= '0;
        end
        else if (adv)
        begin
            s3_tag <= in_tag;
            s4_tag <= s3_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_q    <= prod[SUM_W +: SUM_W];
            s3_sum  <= in_sum;
            s3_held <= in_held;
            s4_q    <= s3_q;
            s4_back <= back[SUM_W-1:0];
            s4_sum  <= s3_sum;
            s4_held <= s3_held;
        end
    end

    always_comb
    begin
        rem  = s4_sum - s4_back;
        quot = (rem >= SUM_W'(s4_held)) ? s4_q + SUM_W'(1) : s4_q;
    end

    assign out_tag = s4_tag;
    assign out_avg = quot[SAMPLE_W-1:0];

endmodule

FILE: design/sfa_outbuf.sv
// Output register with a skid entry; sets the pipeline advance for every stage.
// Depends on sfa_pkg and sfa_out_if.
module sfa_outbuf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfa_pkg::sfa_tag_t             in_tag,
    input  logic [sfa_pkg::SAMPLE_W-1:0]  in_avg,
    sfa_out_if.source                     averages,
    output logic                          adv
);
    import sfa_pkg::*;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_avg_reg;
    logic                out_end_reg;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic [SAMPLE_W-1:0] skid_avg_reg;
    logic                skid_end_reg;
    logic                new_valid;
    logic                load_out;
    logic                load_skid;

    assign adv       = !skid_valid_reg;
    assign new_valid = in_tag.valid && adv;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (averages.ready)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || averages.ready)
        begin
            out_valid_next = new_valid;
            load_out       = 1'b1;
        end
        else if (new_valid)
        begin
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && averages.ready)
        begin
            out_avg_reg <= skid_avg_reg;
            out_end_reg <= skid_end_reg;
        end
        else if (load_out)
        begin
            out_avg_reg <= in_avg;
            out_end_reg <= in_tag.frame_end;
        end
        if (load_skid)
        begin
            skid_avg_reg <= in_avg;
            skid_end_reg <= in_tag.frame_end;
        end
    end

    assign averages.valid      = out_valid_reg;
    assign averages.avg_sample = out_avg_reg;
    assign averages.frame_end  = out_end_reg;

endmodule

FILE: design/spectrum_frame_averager.sv
// Running per-pixel average over the most recent frames of a spectrometer pixel stream.
// Top level; depends on sfa_pkg, sfa_if, sfa_front, sfa_accum, sfa_divide, sfa_outbuf.
//
// Usage:
//   pixels carries one detector item per handshake (sample, last_in_frame, restart);
//   averages returns one item per input item (avg_sample, frame_end), in order.
//   cfg_we/cfg_wdata write frame_limit; write only while no item is in flight.
//   A frame ends at last_in_frame or after PIXELS items. restart on a frame's first
//   item empties the history before that frame.
// Timing:
//   One item per cycle is sustained while averages is ready: history read, sum update,
//   reciprocal multiply, back multiply and correction each take one stage, and each memory
//   takes one read and one write a cycle.
// Reset:
//   Clears the pointers, frame count and pipeline valid bits; frame_limit returns to 1.
//   The memories are not cleared and need no clearing pass.
// Stall:
//   When averages is held, the output register keeps its item and one more item lands
//   in the skid entry; then pixels.ready drops and every stage holds.
module spectrum_frame_averager #(
    parameter int MAX_FRAMES = 16,
    parameter int PIXELS     = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfa_pkg::LIMIT_W-1:0]   cfg_wdata,
    sfa_in_if.sink                        pixels,
    sfa_out_if.source                     averages
);
    import sfa_pkg::*;

    localparam int HELD_W = $clog2(MAX_FRAMES + 1);
    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_FRAMES);

    logic                adv;
    logic [PIX_W-1:0]    rd_pix;
    logic [SLOT_W-1:0]   rd_slot;
    sfa_ctrl_t           s1_ctrl;
    logic [SAMPLE_W-1:0] s1_sample;
    logic [PIX_W-1:0]    s1_pix;
    logic [SLOT_W-1:0]   s1_old;
    logic [SLOT_W-1:0]   s1_new;
    logic [HELD_W-1:0]   s1_held;
    sfa_tag_t            s2_tag;
    logic [SUM_W-1:0]    s2_sum;
    logic [HELD_W-1:0]   s2_held;
    sfa_tag_t            div_tag;
    logic [SAMPLE_W-1:0] div_avg;

    sfa_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .PIXELS     (PIXELS),
        .HELD_W     (HELD_W),
        .SLOT_W     (SLOT_W),
        .PIX_W      (PIX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pixels    (pixels),
        .rd_pix    (rd_pix),
        .rd_slot   (rd_slot),
        .s1_ctrl   (s1_ctrl),
        .s1_sample (s1_sample),
        .s1_pix    (s1_pix),
        .s1_old    (s1_old),
        .s1_new    (s1_new),
        .s1_held   (s1_held)
    );

    sfa_accum #(
        .PIXELS (PIXELS),
        .HELD_W (HELD_W),
        .SLOT_W (SLOT_W),
        .PIX_W  (PIX_W),
        .SUM_W  (SUM_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rd_pix    (rd_pix),
        .rd_slot   (rd_slot),
        .s1_ctrl   (s1_ctrl),
        .s1_sample (s1_sample),
        .s1_pix    (s1_pix),
        .s1_old    (s1_old),
        .s1_new    (s1_new),
        .s1_held   (s1_held),
        .s2_tag    (s2_tag),
        .s2_sum    (s2_sum),
        .s2_held   (s2_held)
    );

    sfa_divide #(
        .MAX_FRAMES (MAX_FRAMES),
        .HELD_W     (HELD_W),
        .SUM_W      (SUM_W)
    ) u_divide (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_tag  (s2_tag),
        .in_sum  (s2_sum),
        .in_held (s2_held),
        .out_tag (div_tag),
        .out_avg (div_avg)
    );

    sfa_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (div_tag),
        .in_avg   (div_avg),
        .averages (averages),
        .adv      (adv)
    );

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ctrl.valid |-> (s1_held != '0) && (s1_held <= HELD_W'(MAX_FRAMES)))
        else $error("frame count out of range");

    a_ring_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ctrl.valid && s1_ctrl.drop |-> (s1_old != s1_new) || (s1_held == HELD_W'(MAX_FRAMES)))
        else $error("newest slot overwrites a held frame");

    a_skid_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> averages.valid)
        else $error("input stalled with an empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pixels.ready) |-> $past(averages.valid && !averages.ready))
        else $error("skid entry filled while output was free");

endmodule
